// ===== rtl/core/average_true_range_defines.svh =====
// Assertion macros for the average true range block.
`ifndef AVERAGE_TRUE_RANGE_DEFINES_SVH
`define AVERAGE_TRUE_RANGE_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define ATR_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("atr: invariant violated");

// Check that a condition implies another in the same cycle.
`define ATR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atr: implication violated");

`endif

// ===== rtl/core/atr_pkg.sv =====
// Shared types and constants for the average true range block.
package atr_pkg;

  localparam int PRICE_BITS      = 32;
  localparam int PERIOD_W        = 7;
  localparam int MAX_PERIOD_DEF  = 64;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;

  // One closed price bar.
  typedef struct packed {
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] close_price;
  } bar_t;

  // One result word.
  typedef struct packed {
    logic [PRICE_BITS-1:0] true_range;
    logic [PRICE_BITS-1:0] average_range;
    logic                  valid_res;
  } atr_res_t;

endpackage

// ===== rtl/core/average_true_range.sv =====
// Average true range: each accepted bar word (high, low, close) yields one result word
// with the bar's true range and the window sum of the last period true ranges divided
// by period. After acceptance a bar passes through these states in order: S_READ to form
// the true range and read the ring, S_UPDATE to update the ring and sum, S_DIV for the
// bit-serial divider, S_DONE to hand the result to the output register, and S_IDLE, in
// which the next bar is taken. Bars that come before the window fills skip the divider.
// A new bar is taken while a finished result still waits on out_stall. Writing period
// clears the window at once (no clearing pass); the next bar counts as the first.
module average_true_range
  import atr_pkg::*;
#(
  parameter int MAX_PERIOD = MAX_PERIOD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bar_t                in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output atr_res_t            out_word,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data
);

  `include "average_true_range_defines.svh"

  localparam int PTR_W  = $clog2(MAX_PERIOD);
  localparam int SUM_W  = PRICE_BITS + $clog2(MAX_PERIOD);
  localparam int CMP_W  = ((PTR_W > PERIOD_W) ? PTR_W : PERIOD_W) + 1;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam logic [PERIOD_W-1:0] P_LIMIT =
    (MAX_PERIOD > 127) ? {PERIOD_W{1'b1}} : PERIOD_W'(MAX_PERIOD);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_UPDATE, S_DIV, S_DONE} state_t;

  state_t                  state;
  logic [PERIOD_W-1:0]     period;
  logic [PERIOD_W-1:0]     p_eff;
  logic [SUM_W-1:0]        window_sum;
  logic [PRICE_BITS-1:0]   previous_close;
  logic [PTR_W-1:0]        ring_pointer;
  logic                    wrapped;
  logic [PERIOD_W-1:0]     bars_seen;
  bar_t                    bar;
  logic [PRICE_BITS-1:0]   tr;
  logic                    res_valid;
  logic [SUM_W-1:0]        quo;
  logic [PERIOD_W-1:0]     rem;
  logic [PERIOD_W-1:0]     divisor;
  logic [DCNT_W-1:0]       div_cnt;

  logic [PRICE_BITS-1:0]   rd_data;
  logic                    ram_we;
  logic [PRICE_BITS-1:0]   d_hl, d_hc, d_lc, tr_next;
  logic [PRICE_BITS-1:0]   old_tr;
  logic [SUM_W-1:0]        window_sum_next;
  logic [PTR_W-1:0]        ring_pointer_next;
  logic                    wrap_now;
  logic [PERIOD_W-1:0]     bars_seen_next;
  logic [PERIOD_W:0]       rem_sh;
  logic                    q_bit;

  // Clamp the period register into the supported range.
  always_comb begin
    if (period == '0) begin
      p_eff = PERIOD_W'(1);
    end else if (period > P_LIMIT) begin
      p_eff = P_LIMIT;
    end else begin
      p_eff = period;
    end
  end

  // Form the true range from the held bar and the previous close.
  always_comb begin
    d_hl = (bar.high_price >= bar.low_price) ? bar.high_price - bar.low_price
                                             : bar.low_price - bar.high_price;
    d_hc = (bar.high_price >= previous_close) ? bar.high_price - previous_close
                                              : previous_close - bar.high_price;
    d_lc = (bar.low_price >= previous_close) ? bar.low_price - previous_close
                                             : previous_close - bar.low_price;
    tr_next = d_hl;
    if (bars_seen != '0) begin
      if (d_hc > tr_next) begin
        tr_next = d_hc;
      end
      if (d_lc > tr_next) begin
        tr_next = d_lc;
      end
    end
  end

  // Update ring pointer, fill flag, bar count and running sum.
  always_comb begin
    old_tr   = wrapped ? rd_data : '0;
    wrap_now = (CMP_W'(ring_pointer) + CMP_W'(1)) >= CMP_W'(p_eff);
    ring_pointer_next = wrap_now ? '0 : ring_pointer + PTR_W'(1);
    window_sum_next = window_sum - SUM_W'(old_tr) + SUM_W'(tr);
    bars_seen_next  = (bars_seen < p_eff) ? bars_seen + PERIOD_W'(1) : bars_seen;
    ram_we = (state == S_UPDATE) && (bars_seen != '0);
  end

  // One restoring divide step.
  always_comb begin
    rem_sh = {rem, quo[SUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, divisor});
  end

  assign in_stall = (state != S_IDLE);

  atr_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (MAX_PERIOD)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_pointer),
    .wdata (tr),
    .raddr (ring_pointer),
    .rdata (rd_data)
  );

  // Sequence one bar through read, update, divide and delivery.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      period         <= PERIOD_RESET;
      window_sum     <= '0;
      previous_close <= '0;
      ring_pointer   <= '0;
      wrapped        <= 1'b0;
      bars_seen      <= '0;
      out_valid      <= 1'b0;
      div_cnt        <= '0;
    end else begin
      // Drop the output word once taken, unless a new one replaces it.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            bar   <= in_word;
            state <= S_READ;
          end
        end
        S_READ: begin
          tr    <= tr_next;
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (bars_seen != '0) begin
            window_sum   <= window_sum_next;
            ring_pointer <= ring_pointer_next;
            if (wrap_now) begin
              wrapped <= 1'b1;
            end
          end
          bars_seen      <= bars_seen_next;
          previous_close <= bar.close_price;
          res_valid      <= (bars_seen_next >= p_eff);
          rem            <= '0;
          divisor        <= p_eff;
          div_cnt        <= DCNT_W'(SUM_W);
          if (bars_seen_next >= p_eff) begin
            quo   <= (bars_seen != '0) ? window_sum_next : window_sum;
            state <= S_DIV;
          end else begin
            quo   <= '0;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          rem     <= q_bit ? PERIOD_W'(rem_sh - {1'b0, divisor}) : rem_sh[PERIOD_W-1:0];
          quo     <= {quo[SUM_W-2:0], q_bit};
          div_cnt <= div_cnt - DCNT_W'(1);
          if (div_cnt == DCNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || !out_stall) begin
            out_word.true_range    <= tr;
            out_word.average_range <= quo[PRICE_BITS-1:0];
            out_word.valid_res     <= res_valid;
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Take a new period and clear the window.
      if (cfg_we) begin
        period         <= cfg_data;
        window_sum     <= '0;
        previous_close <= '0;
        ring_pointer   <= '0;
        wrapped        <= 1'b0;
        bars_seen      <= '0;
      end
    end
  end

  // Bar count never runs past the period.
  `ATR_ASSERT_ALWAYS(a_bars_bound, bars_seen <= p_eff)
  // A full ring means the bar count has saturated.
  `ATR_ASSERT_IMPLY(a_wrap_full, wrapped, bars_seen == p_eff)
  // An empty window has no sum and a home pointer.
  `ATR_ASSERT_IMPLY(a_empty_clear, bars_seen == '0, (window_sum == '0) && (ring_pointer == '0))

endmodule

// ===== rtl/core/atr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module atr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with the read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== bench/tb_average_true_range.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the average true range block with a built-in predictor.
module tb_average_true_range;
  import atr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AT_BAR    = 300;
  localparam int PHASE_BARS     = 87;
  localparam int TAIL_BARS      = 150;
  localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

  logic                clk;
  logic                rst;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  bar_t                in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  atr_res_t            out_word;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_data;

  average_true_range u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // Predictor state: period register, true range history and running window sum
  logic [PERIOD_W-1:0]   period_q;
  logic [PRICE_BITS-1:0] range_hist [MAX_PERIOD_DEF];
  logic [63:0]           range_sum;
  logic [PRICE_BITS-1:0] last_close;
  int                    hist_ptr;
  int                    bar_count;

  bar_t     bar_backlog [$];
  atr_res_t atr_expected [$];

  int bars_sent      = 0;
  int results_seen   = 0;
  int errors         = 0;
  int idle_cycles    = 0;
  int periods_tried  = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;
  bit word_taken     = 1'b0;
  bit quiet_tail     = 1'b0;
  bit rail_flip      = 1'b0;
  logic [PRICE_BITS-1:0] walk_price = 32'h4000_0000;

  function automatic logic [PRICE_BITS-1:0] abs_gap(logic [PRICE_BITS-1:0] a,
                                                    logic [PRICE_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void clear_history();
    foreach (range_hist[i]) range_hist[i] = '0;
    range_sum  = '0;
    last_close = '0;
    hist_ptr   = 0;
    bar_count  = 0;
  endfunction

  // Advance the predictor by one bar and return the result word it yields
  function automatic atr_res_t compute_atr(bar_t b);
    int                    p;
    logic [PRICE_BITS-1:0] tr;
    logic [PRICE_BITS-1:0] th;
    logic [PRICE_BITS-1:0] tl;
    atr_res_t              r;
    p = (period_q == 0) ? 1 :
        (period_q > MAX_PERIOD_DEF) ? MAX_PERIOD_DEF : int'(period_q);
    tr = abs_gap(b.high_price, b.low_price);
    // The first bar after a clear only sets the previous close
    if (bar_count != 0) begin
      th = abs_gap(b.high_price, last_close);
      tl = abs_gap(b.low_price, last_close);
      if (th > tr) tr = th;
      if (tl > tr) tr = tl;
      if (hist_ptr >= p) hist_ptr = 0;
      range_sum = range_sum - 64'(range_hist[hist_ptr]) + 64'(tr);
      range_hist[hist_ptr] = tr;
      hist_ptr = (hist_ptr + 1 >= p) ? 0 : hist_ptr + 1;
    end
    if (bar_count < p) bar_count++;
    last_close      = b.close_price;
    r.true_range    = tr;
    r.valid_res     = (bar_count >= p);
    r.average_range = r.valid_res ? PRICE_BITS'(range_sum / 64'(p)) : '0;
    return r;
  endfunction

  task automatic queue_bar(logic [PRICE_BITS-1:0] h, logic [PRICE_BITS-1:0] l,
                           logic [PRICE_BITS-1:0] c);
    bar_t b;
    b.high_price  = h;
    b.low_price   = l;
    b.close_price = c;
    bar_backlog.push_back(b);
  endtask

  // Queue random bars: a price walk with plausible bars, fully random words and rail values
  task automatic queue_random(int count, int rail_pct);
    bar_t                  b;
    logic [PRICE_BITS-1:0] up;
    logic [PRICE_BITS-1:0] down;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < rail_pct) begin
        if ($urandom_range(0, 1) == 0) begin
          rail_flip = ~rail_flip;
          b = rail_flip ? '1 : '0;
        end else begin
          b.high_price  = $urandom_range(0, 1) ? PRICE_MAX : '0;
          b.low_price   = $urandom_range(0, 1) ? PRICE_MAX : '0;
          b.close_price = $urandom_range(0, 1) ? PRICE_MAX : '0;
        end
      end else if ($urandom_range(0, 3) == 0) begin
        b.high_price  = $urandom;
        b.low_price   = $urandom;
        b.close_price = $urandom;
      end else begin
        walk_price = walk_price + $urandom_range(0, 4000) - 2000;
        if (walk_price < 32'd100000 || walk_price > 32'hFFF0_0000)
          walk_price = $urandom_range(32'h0100_0000, 32'hF000_0000);
        up            = $urandom_range(0, 1500);
        down          = $urandom_range(0, 1500);
        b.high_price  = walk_price + up;
        b.low_price   = walk_price - down;
        b.close_price = b.low_price + $urandom_range(0, up + down);
      end
      bar_backlog.push_back(b);
    end
  endtask

  // Hold until every queued bar has gone in and every result has come out
  task automatic wait_idle();
    while (bar_backlog.size() != 0 || atr_expected.size() != 0) @(posedge clk);
  endtask

  task automatic set_period(logic [PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    periods_tried++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predict on each accepted bar word and check each accepted result word
  always @(posedge clk) begin : scoreboard
    atr_res_t want;
    bit       moved;
    moved = 1'b0;
    if (rst) begin
      period_q = PERIOD_RESET;
      clear_history();
    end else begin
      if (cfg_we) begin
        period_q = cfg_data;
        clear_history();
      end
      if (in_valid && !in_stall) begin
        atr_expected.push_back(compute_atr(in_word));
        void'(bar_backlog.pop_front());
        word_taken = 1'b1;
        bars_sent++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        if (atr_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
        end else begin
          want = atr_expected.pop_front();
          if (out_word.true_range !== want.true_range) begin
            errors++;
            $display("%0t: true_range expected %h actual %h", $time,
                     want.true_range, out_word.true_range);
          end
          if (out_word.average_range !== want.average_range) begin
            errors++;
            $display("%0t: average_range expected %h actual %h", $time,
                     want.average_range, out_word.average_range);
          end
          if (out_word.valid_res !== want.valid_res) begin
            errors++;
            $display("%0t: valid_res expected %b actual %b", $time,
                     want.valid_res, out_word.valid_res);
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Drive bar words from the backlog with random gaps; hold a word until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!quiet_tail && bar_backlog.size() != 0 && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 8) - 1;
        in_valid <= 1'b0;
      end else if (bar_backlog.size() != 0) begin
        in_valid <= 1'b1;
        in_word  <= bar_backlog[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive output stall: random bursts, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && bars_sent >= HOLD_AT_BAR) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus sequence
  initial begin
    logic [PERIOD_W-1:0] phase_periods [9];
    phase_periods = '{7'd64, 7'd2, 7'd65, 7'd100, 7'd3, 7'd33, 7'd14, 7'd1, 7'd50};
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset period: first bar, rails, high below low, closes above and below the bar
    queue_bar(PRICE_MAX, 32'd0, PRICE_MAX);
    queue_bar(32'd0, 32'd0, 32'd0);
    queue_bar(32'd0, PRICE_MAX, 32'd12345);
    queue_bar(32'd100, 32'd50, 32'd70);
    queue_bar(PRICE_MAX, PRICE_MAX, 32'd0);
    queue_bar(32'd5, 32'd5, 32'd5);
    queue_random(40, 10);
    wait_idle();

    // Period of one: the first bar is valid with a zero average
    set_period(7'd1);
    queue_bar(32'd10, 32'd20, 32'd15);
    queue_bar(32'd30, 32'd25, 32'd28);
    queue_bar(32'd0, PRICE_MAX, 32'd0);
    wait_idle();

    // Period zero acts as one
    set_period(7'd0);
    queue_bar(PRICE_MAX, 32'd0, 32'd0);
    queue_bar(32'd7, 32'd7, 32'd7);
    wait_idle();

    // Period above the maximum acts as the maximum; fill the window with rail ranges
    set_period(7'd127);
    queue_bar(32'd1, 32'd2, 32'd3);
    queue_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX);
    queue_random(80, 60);
    wait_idle();

    // Random phases across periods, each write clearing a live window
    foreach (phase_periods[i]) begin
      set_period(phase_periods[i]);
      queue_random(PHASE_BARS, (phase_periods[i] >= 7'd64) ? 50 : 10);
      wait_idle();
    end
    set_period(7'($urandom_range(1, 64)));
    queue_random(PHASE_BARS, 10);
    wait_idle();

    // Final stretch with no idling on either side
    quiet_tail = 1'b1;
    set_period(7'($urandom_range(1, 64)));
    queue_random(TAIL_BARS, 10);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bars and %0d results over %0d period writes,", bars_sent,
             results_seen, periods_tried);
    $display("with edge prices, rail windows, out-of-range periods and a long output hold.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
